// ===== design/dse_pkg.sv =====
// Shared widths, codes and types for the disjoint-set engine.
package dse_pkg;

    localparam int unsigned IDX_W   = 16;  // element index width
    localparam int unsigned POP_W   = 17;  // set population width
    localparam int unsigned CNT_W   = 17;  // element_count register width
    localparam int unsigned SDATA_W = 32;  // slave tdata width
    localparam int unsigned MDATA_W = 40;  // master tdata width (35 bits used)
    localparam int unsigned MPAD_W  = MDATA_W - IDX_W - POP_W - 2;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(65536);

    // Request kind carried on tuser
    typedef enum logic {
        ACT_MERGE = 1'b0,
        ACT_FIND  = 1'b1
    } t_action;

    // Result status code
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_SAME = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

endpackage

// ===== design/disjoint_set_engine.sv =====
// Disjoint-set engine: usage
// Union-find table over CAPACITY elements, kept in two single-port synchronous
// memories (parent links and set populations) with registered read data.
// Slave stream: s_axis_tuser selects merge (0) or find (1); s_axis_tdata holds
// first_index and second_index. Master stream returns one result per request:
// root_index, members and status (0 done, 1 already same set, 2 bad operands).
// i_cfg_we/i_cfg_wdata write element_count; write it only while idle.
// The root walk costs one memory read per parent link, following the chain
// from the index to its root; a merge walks the chains of both operands,
// and bad operands skip the walk.
// One request is in flight at a time; the parent memory port sets the pace.
// The next request is taken while a finished result waits on the master side.
// After reset a clearing pass over all CAPACITY addresses writes
// every parent link to its own index and every population to one; s_axis_tready
// stays low until it ends. Configuration writes are taken during that pass.
// A master-side stall holds the result in the output register; a following
// request still runs and then waits for the output register to drain.
module disjoint_set_engine
    import dse_pkg::*;
#(
    parameter int unsigned CAPACITY = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: element_count
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    // request stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [SDATA_W-1:0] s_axis_tdata,  // [15:0] first_index, [31:16] second_index
    input  logic               s_axis_tuser,  // [0] action
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [MDATA_W-1:0] m_axis_tdata   // [15:0] root_index, [32:16] members,
                                              // [34:33] status, [39:35] zero
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_POP_RD,
        S_POP_LO,
        S_POP_HI,
        S_POP_ZERO,
        S_OUT
    } t_state;

    // control and working registers
    t_state             r_state,   n_state;
    logic [AW-1:0]      r_clr,     n_clr;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic               r_m_valid, n_m_valid;
    t_action            r_action,  n_action;
    logic [IDX_W-1:0]   r_x,       n_x;
    logic [IDX_W-1:0]   r_b,       n_b;
    logic [IDX_W-1:0]   r_ra,      n_ra;
    logic [IDX_W-1:0]   r_lo,      n_lo;
    logic [IDX_W-1:0]   r_hi,      n_hi;
    logic [POP_W-1:0]   r_plo,     n_plo;
    logic [IDX_W-1:0]   r_root,    n_root;
    logic [POP_W-1:0]   r_members, n_members;
    t_status            r_status,  n_status;
    logic [IDX_W-1:0]   r_o_root,    n_o_root;
    logic [POP_W-1:0]   r_o_members, n_o_members;
    t_status            r_o_status,  n_o_status;

    // memories and their ports
    logic [IDX_W-1:0]   r_parent_mem [CAPACITY];
    logic [POP_W-1:0]   r_pop_mem    [CAPACITY];
    logic [IDX_W-1:0]   r_p_rdata;
    logic [POP_W-1:0]   r_q_rdata;
    logic               w_p_we,   w_q_we;
    logic [AW-1:0]      w_p_addr, w_q_addr;
    logic [IDX_W-1:0]   w_p_wdata;
    logic [POP_W-1:0]   w_q_wdata;

    // request decode
    logic [IDX_W-1:0]   w_a, w_b;
    logic               w_a_ok, w_b_ok, w_bad;
    logic [POP_W-1:0]   w_sum;
    logic [IDX_W-1:0]   w_lo, w_hi;

    assign w_a    = s_axis_tdata[IDX_W-1:0];
    assign w_b    = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_a_ok = ({1'b0, w_a} < r_count) && (32'(w_a) < CAPACITY);
    assign w_b_ok = ({1'b0, w_b} < r_count) && (32'(w_b) < CAPACITY);
    assign w_bad  = (t_action'(s_axis_tuser) == ACT_FIND) ? !w_a_ok
                                                          : !((w_a < w_b) && w_b_ok);
    assign w_sum  = r_plo + r_q_rdata;
    assign w_lo   = (r_ra < r_x) ? r_ra : r_x;
    assign w_hi   = (r_ra < r_x) ? r_x : r_ra;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{MPAD_W{1'b0}}, r_o_status, r_o_members, r_o_root};

    // sequencer: walk, read populations, link and write back
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_count     = r_count;
        n_m_valid   = r_m_valid;
        n_action    = r_action;
        n_x         = r_x;
        n_b         = r_b;
        n_ra        = r_ra;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_plo       = r_plo;
        n_root      = r_root;
        n_members   = r_members;
        n_status    = r_status;
        n_o_root    = r_o_root;
        n_o_members = r_o_members;
        n_o_status  = r_o_status;
        w_p_we      = 1'b0;
        w_p_addr    = AW'(r_x);
        w_p_wdata   = r_lo;
        w_q_we      = 1'b0;
        w_q_addr    = AW'(r_lo);
        w_q_wdata   = '0;

        if (i_cfg_we) begin
            n_count = i_cfg_wdata;
        end
        // drop the result once transferred
        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_p_we    = 1'b1;
                w_q_we    = 1'b1;
                w_p_addr  = r_clr;
                w_q_addr  = r_clr;
                w_p_wdata = IDX_W'(r_clr);
                w_q_wdata = POP_W'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                w_p_addr = AW'(w_a);
                if (s_axis_tvalid) begin
                    n_action = t_action'(s_axis_tuser);
                    n_x      = w_a;
                    n_b      = w_b;
                    if (w_bad) begin
                        n_root    = '0;
                        n_members = '0;
                        n_status  = ST_BAD;
                        n_state   = S_OUT;
                    end else begin
                        n_state = S_WALK_A;
                    end
                end
            end
            S_WALK_A: begin
                if (r_p_rdata == r_x) begin
                    n_ra = r_x;
                    if (r_action == ACT_FIND) begin
                        w_q_addr = AW'(r_x);
                        n_root   = r_x;
                        n_status = ST_DONE;
                        n_state  = S_POP_RD;
                    end else begin
                        n_x      = r_b;
                        w_p_addr = AW'(r_b);
                        n_state  = S_WALK_B;
                    end
                end else begin
                    n_x      = r_p_rdata;
                    w_p_addr = AW'(r_p_rdata);
                end
            end
            S_WALK_B: begin
                if (r_p_rdata == r_x) begin
                    if (r_x == r_ra) begin
                        w_q_addr = AW'(r_ra);
                        n_root   = r_ra;
                        n_status = ST_SAME;
                        n_state  = S_POP_RD;
                    end else begin
                        n_lo     = w_lo;
                        n_hi     = w_hi;
                        w_q_addr = AW'(w_lo);
                        n_root   = w_lo;
                        n_status = ST_DONE;
                        n_state  = S_POP_LO;
                    end
                end else begin
                    n_x      = r_p_rdata;
                    w_p_addr = AW'(r_p_rdata);
                end
            end
            S_POP_RD: begin
                n_members = r_q_rdata;
                n_state   = S_OUT;
            end
            S_POP_LO: begin
                n_plo    = r_q_rdata;
                w_q_addr = AW'(r_hi);
                n_state  = S_POP_HI;
            end
            S_POP_HI: begin
                // link the absorbed root and add the populations
                w_q_we    = 1'b1;
                w_q_addr  = AW'(r_lo);
                w_q_wdata = w_sum;
                w_p_we    = 1'b1;
                w_p_addr  = AW'(r_hi);
                w_p_wdata = r_lo;
                n_members = w_sum;
                n_state   = S_POP_ZERO;
            end
            S_POP_ZERO: begin
                w_q_we    = 1'b1;
                w_q_addr  = AW'(r_hi);
                w_q_wdata = '0;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_o_root    = r_root;
                    n_o_members = r_members;
                    n_o_status  = r_status;
                    n_m_valid   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_x         <= n_x;
        r_b         <= n_b;
        r_ra        <= n_ra;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_plo       <= n_plo;
        r_root      <= n_root;
        r_members   <= n_members;
        r_status    <= n_status;
        r_o_root    <= n_o_root;
        r_o_members <= n_o_members;
        r_o_status  <= n_o_status;
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_count   <= COUNT_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    // parent link memory
    always_ff @(posedge i_clk) begin
        if (w_p_we) begin
            r_parent_mem[w_p_addr] <= w_p_wdata;
        end
        r_p_rdata <= r_parent_mem[w_p_addr];
    end

    // set population memory
    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            r_pop_mem[w_q_addr] <= w_q_wdata;
        end
        r_q_rdata <= r_pop_mem[w_q_addr];
    end

    // no request taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("request accepted during clearing pass");

    // parent links always point to an equal or smaller index
    a_link_downward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK_A) || (r_state == S_WALK_B)) |-> (r_p_rdata <= r_x))
        else $error("parent link points upward");

    // a rejected request reports an empty result
    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_o_status == ST_BAD)) |-> ((r_o_root == '0) && (r_o_members == '0)))
        else $error("bad-operand result carries data");

    // an accepted request reports a non-empty set
    a_good_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_o_status != ST_BAD)) |-> (r_o_members != '0))
        else $error("valid result with empty set");

    // a merge links the larger root under the smaller one
    a_merge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_HI) |-> (r_lo < r_hi))
        else $error("merge root order broken");

endmodule

// ===== test/disjoint_set_engine_tb.sv =====
// Self-checking stream testbench for the disjoint-set engine with a union-find predictor.
`timescale 1ns / 1ps

module disjoint_set_engine_tb;
    import dse_pkg::*;

    localparam int unsigned CAP = 65536;

    // One queued request and its hold-off before it is offered
    typedef struct packed {
        t_action          act;
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic [2:0]       gap;
    } t_request;

    // One result as the engine should return it
    typedef struct packed {
        logic [IDX_W-1:0] root;
        logic [POP_W-1:0] members;
        t_status          status;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [SDATA_W-1:0] s_axis_tdata = '0;   // [15:0] first_index, [31:16] second_index
    logic               s_axis_tuser = 1'b0; // [0] action
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [MDATA_W-1:0] m_axis_tdata;        // [15:0] root_index, [32:16] members,
                                             // [34:33] status

    // Shadow union-find table and element_count
    logic [IDX_W-1:0] parent_tbl [0:CAP-1];
    logic [POP_W-1:0] pop_tbl [0:CAP-1];
    logic [CNT_W-1:0] elem_count = COUNT_RESET;

    t_request    request_queue[$];
    t_result     predicted_results[$];
    int unsigned requests_issued = 0;
    int unsigned requests_taken = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned cycle_budget = 4 * CAP + 20000;
    int unsigned phase_no = 0;

    // Handshake bookkeeping shared between the edges
    logic        req_taken = 1'b0;
    logic        result_taken = 1'b0;
    t_request    staged;
    logic        staged_valid = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    disjoint_set_engine #(
        .CAPACITY (CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Follow parent links up to the root, counting the hops taken
    function automatic logic [IDX_W-1:0] climb_to_root(input logic [IDX_W-1:0] start,
                                                        inout int unsigned steps);
        logic [IDX_W-1:0] node;
        int unsigned      hops;
        node = start;
        hops = 0;
        while (parent_tbl[node] != node && hops < CAP) begin
            node = parent_tbl[node];
            hops++;
        end
        steps += hops;
        return node;
    endfunction

    // Apply one find or merge to the shadow table and return its result
    function automatic void resolve_request(input t_action act,
                                            input logic [IDX_W-1:0] a,
                                            input logic [IDX_W-1:0] b,
                                            output t_result res,
                                            output int unsigned steps);
        int unsigned      lim;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        lim = (elem_count > CAP) ? CAP : elem_count;
        res.root = '0;
        res.members = '0;
        res.status = ST_BAD;
        steps = 0;
        if (act == ACT_FIND) begin
            if (a < lim) begin
                ra = climb_to_root(a, steps);
                res.root = ra;
                res.members = pop_tbl[ra];
                res.status = ST_DONE;
            end
        end else if (a < b && b < lim) begin
            ra = climb_to_root(a, steps);
            rb = climb_to_root(b, steps);
            if (ra == rb) begin
                res.root = ra;
                res.members = pop_tbl[ra];
                res.status = ST_SAME;
            end else begin
                // link the larger root under the smaller one
                lo = (ra < rb) ? ra : rb;
                hi = (ra < rb) ? rb : ra;
                parent_tbl[hi] = lo;
                pop_tbl[lo] = pop_tbl[lo] + pop_tbl[hi];
                pop_tbl[hi] = '0;
                res.root = lo;
                res.members = pop_tbl[lo];
                res.status = ST_DONE;
            end
        end
    endfunction

    task automatic queue_request(input t_action act, input logic [IDX_W-1:0] a,
                                 input logic [IDX_W-1:0] b);
        t_request rq;
        rq.act = act;
        rq.first = a;
        rq.second = b;
        rq.gap = tx_quiet ? 3'd0 : 3'($urandom_range(0, 4));
        request_queue = {request_queue, rq};
        requests_issued++;
    endtask

    // Mostly well-formed finds and merges, often in a small hot window, plus noise
    task automatic queue_random_request(input int unsigned lim);
        int unsigned      pick;
        int unsigned      span;
        t_action          act;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        pick = $urandom_range(0, 99);
        span = ($urandom_range(0, 1) && lim > 64) ? 64 : lim;
        act = t_action'($urandom_range(0, 1));
        a = IDX_W'($urandom);
        b = IDX_W'($urandom);
        if (pick < 10) begin
            // raw noise over the whole field range
        end else if (pick < 45) begin
            act = ACT_FIND;
            if (span > 0) a = IDX_W'($urandom_range(0, span - 1));
        end else if (pick < 52) begin
            // merge with the indices out of order or equal
            act = ACT_MERGE;
            if (span > 0) begin
                a = IDX_W'($urandom_range(0, span - 1));
                b = IDX_W'($urandom_range(0, a));
            end
        end else if (pick < 56) begin
            // second index right at the limit
            act = ACT_MERGE;
            if (lim > 0 && lim < CAP) begin
                b = IDX_W'(lim);
                a = IDX_W'($urandom_range(0, lim - 1));
            end
        end else begin
            act = ACT_MERGE;
            if (span >= 2) begin
                b = IDX_W'($urandom_range(1, span - 1));
                a = IDX_W'($urandom_range(0, b - 1));
            end
        end
        queue_request(act, a, b);
    endtask

    // Hold until every queued request has been taken and answered
    task automatic wait_drained();
        do @(negedge i_clk);
        while (requests_taken != requests_issued || predicted_results.size() != 0);
    endtask

    // Optionally rewrite element_count, then run a chain build and random traffic
    task automatic run_phase(input bit write_cfg, input logic [CNT_W-1:0] count,
                             input int n_rand, input int chain_base, input int chain_len);
        int unsigned lim;
        if (write_cfg) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= count;
            elem_count = count;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
        end
        lim = (count > CAP) ? CAP : count;
        phase_no++;
        @(posedge i_clk);
        rx_quiet = (phase_no % 3 == 2);
        tx_quiet = 1'b0;
        // descending adjacent merges build one long parent chain
        for (int k = chain_len - 2; k >= 0; k--) begin
            queue_request(ACT_MERGE, IDX_W'(chain_base + k), IDX_W'(chain_base + k + 1));
        end
        if (chain_len > 0) begin
            queue_request(ACT_FIND, IDX_W'(chain_base + chain_len - 1), '0);
        end
        for (int i = 0; i < n_rand; i++) begin
            tx_quiet = ((i / 40) % 3 == 1);
            queue_random_request(lim);
        end
        wait_drained();
        repeat (4) @(negedge i_clk);
    endtask

    // Count cycles, and predict each request at its transfer
    always @(posedge i_clk) begin : accept_blk
        t_result     res;
        int unsigned steps;
        cycle_count = cycle_count + 1;
        if (cycle_count > cycle_budget) begin
            $display("disjoint_set_engine_tb: errors");
            $finish;
        end else begin
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                resolve_request(t_action'(s_axis_tuser), s_axis_tdata[15:0],
                                s_axis_tdata[31:16], res, steps);
                predicted_results = {predicted_results, res};
                requests_taken++;
                cycle_budget += 20 * (steps + 16);
                req_taken <= 1'b1;
            end else begin
                req_taken <= 1'b0;
            end
        end
    end

    // Drive requests: hold until transfer, then wait out the next gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (!staged_valid && request_queue.size() != 0) begin
                staged = request_queue.pop_front();
                staged_valid = 1'b1;
                gap_left = staged.gap;
            end
            if (staged_valid && gap_left == 0) begin
                s_axis_tdata <= {staged.second, staged.first};
                s_axis_tuser <= staged.act;
                s_axis_tvalid <= 1'b1;
                staged_valid = 1'b0;
            end else begin
                s_axis_tvalid <= 1'b0;
                if (staged_valid) gap_left--;
            end
        end
    end

    // Stall the result side for a random count after each transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (result_taken) stall_left = rx_quiet ? 0 : $urandom_range(0, 4);
            if (stall_left != 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_blk
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_taken <= 1'b1;
            if (predicted_results.size() == 0) begin
                $error("result with nothing pending: root_index %0d members %0d status %0d",
                       m_axis_tdata[15:0], m_axis_tdata[32:16], m_axis_tdata[34:33]);
                error_count++;
            end else begin
                want = predicted_results.pop_front();
                if (m_axis_tdata[15:0] !== want.root) begin
                    $error("root_index: expected %0d, got %0d", want.root, m_axis_tdata[15:0]);
                    error_count++;
                end
                if (m_axis_tdata[32:16] !== want.members) begin
                    $error("members: expected %0d, got %0d", want.members,
                           m_axis_tdata[32:16]);
                    error_count++;
                end
                if (m_axis_tdata[34:33] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[34:33]);
                    error_count++;
                end
            end
        end else begin
            result_taken <= 1'b0;
        end
    end

    initial begin
        for (int i = 0; i < CAP; i++) begin
            parent_tbl[i] = IDX_W'(i);
            pop_tbl[i] = POP_W'(1);
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes, both orders, same set, and a short chain
        queue_request(ACT_FIND, 16'h0000, 16'h0000);
        queue_request(ACT_FIND, 16'hFFFF, 16'hFFFF);
        queue_request(ACT_MERGE, 16'h0000, 16'hFFFF);
        queue_request(ACT_FIND, 16'hFFFF, 16'h0000);
        queue_request(ACT_MERGE, 16'h0000, 16'hFFFF);
        queue_request(ACT_MERGE, 16'hFFFF, 16'h0000);
        queue_request(ACT_MERGE, 16'd5, 16'd5);
        queue_request(ACT_MERGE, 16'd1, 16'd2);
        queue_request(ACT_MERGE, 16'd2, 16'd3);
        queue_request(ACT_MERGE, 16'd3, 16'hFFFF);
        queue_request(ACT_FIND, 16'd3, 16'h1234);
        queue_request(ACT_MERGE, 16'd100, 16'd101);
        queue_request(ACT_MERGE, 16'd99, 16'd100);
        queue_request(ACT_MERGE, 16'd98, 16'd99);
        queue_request(ACT_FIND, 16'd101, 16'd0);
        queue_request(ACT_MERGE, 16'd98, 16'hFFFE);
        queue_request(ACT_MERGE, 16'd3, 16'd101);
        queue_request(ACT_FIND, 16'hFFFE, 16'hFFFF);
        queue_request(ACT_MERGE, 16'h5555, 16'hAAAA);

        // Walk element_count through small, zero, oversized and full settings
        run_phase(1'b0, COUNT_RESET, 100, 0, 0);
        run_phase(1'b1, CNT_W'(16), 120, 0, 16);
        run_phase(1'b1, CNT_W'(1), 30, 0, 0);
        run_phase(1'b1, CNT_W'(0), 30, 0, 0);
        run_phase(1'b1, CNT_W'(131071), 100, 0, 0);
        run_phase(1'b1, CNT_W'(300), 100, 200, 64);
        run_phase(1'b1, CNT_W'(2), 40, 0, 0);
        run_phase(1'b1, CNT_W'(65537), 100, 0, 0);
        run_phase(1'b1, CNT_W'(40), 150, 0, 40);
        run_phase(1'b1, CNT_W'(4096), 100, 1000, 100);
        run_phase(1'b1, COUNT_RESET, 100, 0, 0);

        repeat (16) @(negedge i_clk);
        if (error_count == 0) begin
            $display("disjoint_set_engine_tb: clean");
        end else begin
            $display("disjoint_set_engine_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/dse_pkg.sv
design/disjoint_set_engine.sv
test/disjoint_set_engine_tb.sv
